// ----- rtl/pdh_pkg.sv -----
// Shared types and constants for the half-maximum peak detector.
// Used by pdh_scan and the top level; no dependencies.
package pdh_pkg;

	localparam int WINDOW_DEPTH = 1024;
	localparam int ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SAMPLE_W = 32;
	localparam int ABS_W = 31;
	localparam int REFR_W = 10;
	localparam int MAXREP_W = 6;
	localparam int POS_W = 10;
	localparam int TOTAL_W = 10;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 10;
	localparam logic [MAXREP_W-1:0] MAXREP_RESET = MAXREP_W'(63);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REFRACTORY = 1'b0,
		REG_MAX_REPORTED = 1'b1
	} pdh_reg_t;

	typedef enum logic {
		KIND_PEAK = 1'b0,
		KIND_COUNT = 1'b1
	} pdh_kind_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_READ,
		SC_EVAL,
		SC_FINAL
	} pdh_scan_state_t;

	typedef struct packed {
		logic [REFR_W-1:0] refractory;
		logic [MAXREP_W-1:0] max_reported;
	} pdh_cfg_t;

	// Hand-off from the loader to the scan engine at the end of a window.
	typedef struct packed {
		logic go;
		logic [FILL_W-1:0] count;
		logic signed [SAMPLE_W-1:0] threshold;
		logic dropped;
	} pdh_start_t;

endpackage

// ----- rtl/pdh_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pdh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/pdh_scan.sv -----
// Scan engine: walks the stored window through the RAM read port, tests each
// interior position for a peak and drives the result output register.
// Depends on pdh_pkg.
module pdh_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pdh_pkg::pdh_start_t               start,
	input  pdh_pkg::pdh_cfg_t                 cfg,
	output logic                              idle,
	output logic                              rd_en,
	output logic [pdh_pkg::ADDR_W-1:0]        rd_addr,
	input  logic [pdh_pkg::SAMPLE_W-1:0]      rd_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              item_kind,
	output logic [pdh_pkg::POS_W-1:0]         peak_position,
	output logic [pdh_pkg::TOTAL_W-1:0]       peak_total,
	output logic                              overflowed,
	output logic                              last_result
);
	import pdh_pkg::*;

	localparam int DIST_W = ADDR_W + REFR_W;

	pdh_scan_state_t state_q, state_d;

	logic [FILL_W-1:0] n_q;
	logic [FILL_W-1:0] idx_q;
	logic signed [SAMPLE_W-1:0] thr_q;
	logic drop_q;
	logic [TOTAL_W-1:0] count_q;
	logic have_peak_q;
	logic [ADDR_W-1:0] last_peak_q;
	logic signed [SAMPLE_W-1:0] left_q, center_q;

	logic signed [SAMPLE_W-1:0] right;
	logic [FILL_W-1:0] pos_full;
	logic [ADDR_W-1:0] pos;
	logic [ADDR_W-1:0] gap;
	logic spaced, is_peak, report;
	logic slot_free, advance, load_peak, load_count, last_index;

	assign right = $signed(rd_data);
	assign pos_full = idx_q - FILL_W'(1);
	assign pos = pos_full[ADDR_W-1:0];
	assign gap = pos - last_peak_q;
	assign spaced = !have_peak_q || (DIST_W'(gap) >= DIST_W'(cfg.refractory));
	// The sample arriving now is the right neighbor of the position before it.
	assign is_peak = (idx_q >= FILL_W'(2)) && (center_q > thr_q) && (center_q >= left_q)
		&& (center_q > right) && spaced;
	assign report = is_peak && (count_q < TOTAL_W'(cfg.max_reported));
	assign slot_free = !out_valid || out_ready;
	assign last_index = (idx_q == n_q - FILL_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		advance = 1'b0;
		load_peak = 1'b0;
		load_count = 1'b0;
		rd_en = 1'b0;
		unique case (state_q)
			SC_IDLE: begin
				if (start.go) begin
					state_d = (start.count < FILL_W'(3)) ? SC_FINAL : SC_READ;
				end
			end
			SC_READ: begin
				rd_en = 1'b1;
				state_d = SC_EVAL;
			end
			SC_EVAL: begin
				// A reported peak waits here until the output register has room.
				if (!report || slot_free) begin
					advance = 1'b1;
					load_peak = report;
					state_d = last_index ? SC_FINAL : SC_READ;
				end
			end
			SC_FINAL: begin
				if (slot_free) begin
					load_count = 1'b1;
					state_d = SC_IDLE;
				end
			end
			default: state_d = SC_IDLE;
		endcase
	end

	assign idle = (state_q == SC_IDLE);
	assign rd_addr = idx_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			count_q <= '0;
			have_peak_q <= 1'b0;
			last_peak_q <= '0;
			n_q <= '0;
			drop_q <= 1'b0;
		end else if (state_q == SC_IDLE && start.go) begin
			idx_q <= '0;
			count_q <= '0;
			have_peak_q <= 1'b0;
			last_peak_q <= '0;
			n_q <= start.count;
			drop_q <= start.dropped;
		end else if (advance) begin
			idx_q <= idx_q + FILL_W'(1);
			if (is_peak) begin
				count_q <= count_q + TOTAL_W'(1);
				have_peak_q <= 1'b1;
				last_peak_q <= pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SC_IDLE && start.go) begin
			thr_q <= start.threshold;
		end
		if (advance) begin
			left_q <= center_q;
			center_q <= right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_peak || load_count) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_peak) begin
			item_kind <= KIND_PEAK;
			peak_position <= POS_W'(pos);
			peak_total <= '0;
			overflowed <= drop_q;
			last_result <= 1'b0;
		end else if (load_count) begin
			item_kind <= KIND_COUNT;
			peak_position <= '0;
			peak_total <= count_q;
			overflowed <= drop_q;
			last_result <= 1'b1;
		end
	end

	a_eval_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SC_EVAL |-> idx_q < n_q)
		else $error("scan read beyond the stored window");

	a_report_limit: assert property (@(posedge clk) disable iff (!arst_n)
		load_peak |-> count_q < TOTAL_W'(cfg.max_reported))
		else $error("peak reported past the configured limit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> !$past(load_peak || load_count))
		else $error("output register loaded while a result was pending");

endmodule

// ----- rtl/peak_detector_half_max_refractory_core.sv -----
// Top level of the half-maximum peak detector: sample loader, running maximum,
// configuration registers, sample RAM and scan engine.
// Depends on pdh_pkg, pdh_ram and pdh_scan.
//
//   port group    direction  handshake            carries
//   in_*          input      in_valid/in_ready    sample, last_sample
//   out_*         output     out_valid/out_ready  item_kind, peak_position,
//                                                 peak_total, overflowed, last_result
//   cfg_*         input      cfg_we only          cfg_index, cfg_data
//
// An accepted sample is written to the sample RAM at once unless the window is full;
// then it is dropped. The last sample starts a scan that reads each stored sample
// from RAM and evaluates it, then emits the count result; no new request is taken
// until the scan ends. A blocked output stalls it at a reported peak or count result.
// Reset clears the fill count, maximum, drop flag and registers; RAM is not cleared.
module peak_detector_half_max_refractory_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [pdh_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                item_kind,
	output logic [pdh_pkg::POS_W-1:0]           peak_position,
	output logic [pdh_pkg::TOTAL_W-1:0]         peak_total,
	output logic                                overflowed,
	output logic                                last_result,
	input  logic                                cfg_we,
	input  logic [pdh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pdh_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pdh_pkg::*;

	pdh_cfg_t cfg_q;
	pdh_start_t start;

	logic [FILL_W-1:0] fill_q;
	logic [ABS_W-1:0] max_q;
	logic drop_q;

	logic accept, full, wr_en;
	logic [ABS_W-1:0] abs_val;
	logic scan_idle, rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [SAMPLE_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.refractory <= '0;
			cfg_q.max_reported <= MAXREP_RESET;
		end else if (cfg_we) begin
			unique case (pdh_reg_t'(cfg_index))
				REG_REFRACTORY: cfg_q.refractory <= cfg_data[REFR_W-1:0];
				REG_MAX_REPORTED: cfg_q.max_reported <= cfg_data[MAXREP_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = scan_idle;
	assign accept = in_valid && in_ready;
	assign full = (fill_q == FILL_W'(WINDOW_DEPTH));
	assign wr_en = accept && !full;

	// The most negative sample has no positive counterpart and saturates.
	always_comb begin
		if (!sample[SAMPLE_W-1]) begin
			abs_val = sample[ABS_W-1:0];
		end else if (sample[ABS_W-1:0] == '0) begin
			abs_val = '1;
		end else begin
			abs_val = ABS_W'(-sample);
		end
	end

	always_comb begin
		start.go = accept && last_sample;
		start.count = full ? fill_q : fill_q + FILL_W'(1);
		start.dropped = drop_q || full;
		if (!full && abs_val > max_q) begin
			start.threshold = $signed({2'b00, abs_val[ABS_W-1:1]});
		end else begin
			start.threshold = $signed({2'b00, max_q[ABS_W-1:1]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			max_q <= '0;
			drop_q <= 1'b0;
		end else if (start.go) begin
			fill_q <= '0;
			max_q <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				fill_q <= fill_q + FILL_W'(1);
				if (abs_val > max_q) begin
					max_q <= abs_val;
				end
			end
		end
	end

	pdh_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW_DEPTH)
	) u_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(fill_q[ADDR_W-1:0]),
		.wdata(sample),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	pdh_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cfg(cfg_q),
		.idle(scan_idle),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.peak_position(peak_position),
		.peak_total(peak_total),
		.overflowed(overflowed),
		.last_result(last_result)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("fill count beyond window depth");

	a_clear_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		start.go |=> (fill_q == '0) && !drop_q && !in_ready)
		else $error("window state not cleared when scan started");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !last_sample && !full) |=> fill_q == $past(fill_q) + FILL_W'(1))
		else $error("stored sample not counted");

endmodule
